FILE: rtl/ufd_pkg.sv
// Package for the URL form decoder: item types, byte constants and the
// hex digit decode. No dependencies; used by url_form_decoder.
package ufd_pkg;

    // Item types for the two streaming channels
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Fixed byte values
    localparam logic [7:0] ESC_RESET  = 8'h25;  // percent
    localparam logic [7:0] PLUS_BYTE  = 8'h2B;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    // Hex decode result: ok flag and digit value
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Only 0-9, a-f and A-F count as digits
    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok    = 1'b1;
        h.value = b[3:0];
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            h.value = b[3:0] + 4'd9;
        end else begin
            h.ok    = 1'b0;
            h.value = 4'd0;
        end
        return h;
    endfunction

endpackage

FILE: rtl/url_form_decoder.sv
// URL form decoder top level: phase tracking, hex decode and output buffering.
// Depends on ufd_pkg for item types, constants and the hex decode function.
//
// Decodes a URL form encoded byte stream at one input item per clock while
// in_stall is low. Each accepted item updates a small escape phase register
// and yields zero or one result, written at the same edge to the output
// register (shown on out_valid in the next cycle) or, if that register holds
// a stalled result, to a skid register. The output side holds two results, so
// input keeps flowing while one result waits; in_stall rises only when both
// are full and is itself a register. The escape byte (cfg_data, reset percent)
// is written through the configuration channel, which is always ready; plus
// becomes space unless plus is the escape byte, and a string ending mid-escape
// emits what it has so far with out_last set.
module url_form_decoder
    import ufd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // input stream
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    // output stream
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_FIRST,
        PH_HELD,
        PH_BAD
    } phase_t;

    logic [7:0] escape_reg, escape_next;
    phase_t     phase_reg, phase_next;
    logic [3:0] held_reg, held_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;
    logic       skid_valid_reg, skid_valid_next;
    out_item_t  skid_item_reg, skid_item_next;

    logic       in_fire;
    logic       out_fire;
    logic       has_res;
    logic [7:0] res_byte;
    hex_t       hex;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign hex       = hex_decode(in_data.in_byte);

    // Escape phase and decoded byte for the item at the input
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        has_res    = 1'b1;
        res_byte   = in_data.in_byte;
        case (phase_reg)
            PH_TEXT:
            begin
                if (in_data.in_byte == PLUS_BYTE && escape_reg != PLUS_BYTE) begin
                    res_byte = SPACE_BYTE;
                end else if (in_data.in_byte == escape_reg) begin
                    res_byte = QMARK_BYTE;
                    if (!in_data.in_last) begin
                        has_res    = 1'b0;
                        phase_next = PH_FIRST;
                    end
                end
            end
            PH_FIRST:
            begin
                res_byte   = hex.ok ? {4'd0, hex.value} : QMARK_BYTE;
                phase_next = PH_TEXT;
                if (!in_data.in_last) begin
                    has_res = 1'b0;
                    if (hex.ok) begin
                        held_next  = hex.value;
                        phase_next = PH_HELD;
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
            end
            PH_HELD:
            begin
                res_byte   = hex.ok ? {held_reg, hex.value} : {4'd0, held_reg};
                phase_next = PH_TEXT;
            end
            default:
            begin
                res_byte   = QMARK_BYTE;
                phase_next = PH_TEXT;
            end
        endcase
        if (!in_fire) begin
            phase_next = phase_reg;
            held_next  = held_reg;
            has_res    = 1'b0;
        end
    end

    // Output register, skid register and escape byte update
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        escape_next     = cfg_valid ? cfg_data : escape_reg;
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end else if (has_res) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_next         = 1'b1;
                out_item_next.out_byte = res_byte;
                out_item_next.out_last = in_data.in_last;
            end else begin
                skid_valid_next         = 1'b1;
                skid_item_next.out_byte = res_byte;
                skid_item_next.out_last = in_data.in_last;
            end
        end else if (out_fire) begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            escape_reg     <= ESC_RESET;
            phase_reg      <= PH_TEXT;
            held_reg       <= 4'd0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
            skid_valid_reg <= 1'b0;
            skid_item_reg  <= '0;
        end else begin
            escape_reg     <= escape_next;
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            out_valid_reg  <= out_valid_next;
            out_item_reg   <= out_item_next;
            skid_valid_reg <= skid_valid_next;
            skid_item_reg  <= skid_item_next;
        end
    end

    // Skid entry only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while output register is empty");

    // A waiting result is never dropped
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result vanished");

    // An escape byte mid-string moves to the first digit phase
    a_escape_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_TEXT && in_data.in_byte == escape_reg
            && !in_data.in_last |=> phase_reg == PH_FIRST)
        else $error("escape byte did not start an escape");

    // The last byte of a string always leaves normal text behind
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.in_last |=> phase_reg == PH_TEXT)
        else $error("phase not back to text after last byte");

    // The last byte of a string always yields a result
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.in_last |-> has_res)
        else $error("last byte produced no result");

endmodule
